@@ hw/rtl/sdl_pkg.sv @@
// sdl_pkg: constants, codes, state type and command/status structs of the
// spectral delay line mac; no dependencies
package sdl_pkg;

    localparam int BIN_COUNT      = 512;
    localparam int MAX_PARTITIONS = 16;

    localparam int BIN_W      = $clog2(BIN_COUNT);
    localparam int SLOT_W     = $clog2(MAX_PARTITIONS);
    localparam int PCNT_W     = SLOT_W + 1;
    localparam int HIST_DEPTH = MAX_PARTITIONS * BIN_COUNT;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);

    localparam int DATA_W = 24;
    localparam int FRAC_W = 20;
    localparam int PROD_W = 2 * DATA_W;
    // difference of two products, summed over up to MAX_PARTITIONS terms
    localparam int ACC_W  = PROD_W + 1 + SLOT_W;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_BIN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COEF  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clr_step;   // zero one history word
        logic clr_start;  // clear command accepted: slot and bin to zero
        logic bin_take;   // latch an incoming bin
        logic coef_wr;    // store an incoming coefficient word
        logic hist_wr;    // write latched bin into history, reset mac
        logic rd_issue;   // issue one partition read
        logic out_load;   // load rounded sum into output register
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic rd_last;
        logic pipe_busy;
        logic out_free;
    } status_t;

    // register value 0 acts as 1, values above the maximum are clamped
    function automatic logic [PCNT_W-1:0] part_count(input logic [PCNT_W-1:0] raw);
        logic [PCNT_W-1:0] p;
        p = raw;
        if (raw == '0)
        begin
            p = PCNT_W'(1);
        end
        else if (raw > PCNT_W'(MAX_PARTITIONS))
        begin
            p = PCNT_W'(MAX_PARTITIONS);
        end
        return p;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [BIN_W-1:0] bin);
        return ADDR_W'(slot) * ADDR_W'(BIN_COUNT) + ADDR_W'(bin);
    endfunction

endpackage

@@ hw/rtl/sdl_if.sv @@
// sdl_if: valid/ready stream interfaces for input items and results
// depends on sdl_pkg
interface sdl_in_if;
    logic                               valid;
    logic                               ready;
    logic [sdl_pkg::KIND_W-1:0]         kind;
    logic signed [sdl_pkg::DATA_W-1:0]  value_re;
    logic signed [sdl_pkg::DATA_W-1:0]  value_im;
    logic                               frame_last;
    logic [sdl_pkg::SLOT_W-1:0]         coef_partition;
    logic [sdl_pkg::BIN_W-1:0]          coef_bin;

    modport source (output valid, kind, value_re, value_im, frame_last, coef_partition,
                    coef_bin, input ready);
    modport sink (input valid, kind, value_re, value_im, frame_last, coef_partition,
                  coef_bin, output ready);
endinterface

interface sdl_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sdl_pkg::DATA_W-1:0]  out_re;
    logic signed [sdl_pkg::DATA_W-1:0]  out_im;
    logic                               out_last;
    logic                               saturated;

    modport source (output valid, out_re, out_im, out_last, saturated, input ready);
    modport sink (input valid, out_re, out_im, out_last, saturated, output ready);
endinterface

@@ hw/rtl/sdl_ctrl.sv @@
// sdl_ctrl: sequencing state machine of the spectral delay line mac
// depends on sdl_pkg
module sdl_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  logic [sdl_pkg::KIND_W-1:0] item_kind,
    output logic                       item_ready,
    input  sdl_pkg::status_t           status,
    output sdl_pkg::cmd_t              cmd
);

    sdl_pkg::state_t state_reg;
    sdl_pkg::state_t state_next;
    logic            accept;

    assign item_ready = (state_reg == sdl_pkg::ST_IDLE);
    assign accept     = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdl_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdl_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = sdl_pkg::ST_IDLE;
                end
            end
            sdl_pkg::ST_IDLE:
            begin
                if (accept && item_kind == sdl_pkg::KIND_BIN)
                begin
                    state_next = sdl_pkg::ST_WRITE;
                end
                else if (accept && item_kind == sdl_pkg::KIND_CLEAR)
                begin
                    state_next = sdl_pkg::ST_CLEAR;
                end
            end
            sdl_pkg::ST_WRITE:
            begin
                state_next = sdl_pkg::ST_READ;
            end
            sdl_pkg::ST_READ:
            begin
                if (status.rd_last)
                begin
                    state_next = sdl_pkg::ST_DRAIN;
                end
            end
            sdl_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = sdl_pkg::ST_FINISH;
                end
            end
            sdl_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = sdl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.bin_take  = accept && item_kind == sdl_pkg::KIND_BIN;
        cmd.coef_wr   = accept && item_kind == sdl_pkg::KIND_COEF;
        cmd.clr_start = accept && item_kind == sdl_pkg::KIND_CLEAR;
        cmd.clr_step  = (state_reg == sdl_pkg::ST_CLEAR);
        cmd.hist_wr   = (state_reg == sdl_pkg::ST_WRITE);
        cmd.rd_issue  = (state_reg == sdl_pkg::ST_READ);
        cmd.out_load  = (state_reg == sdl_pkg::ST_FINISH) && status.out_free;
    end

    property p_clear_runs_to_end;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == sdl_pkg::ST_CLEAR) && !status.clr_last |=>
            (state_reg == sdl_pkg::ST_CLEAR);
    endproperty
    a_clear_runs_to_end : assert property (p_clear_runs_to_end)
        else $error("clearing pass left early");

    property p_bin_starts_write;
        @(posedge clk) disable iff (!rst_n)
        cmd.bin_take |=> (state_reg == sdl_pkg::ST_WRITE);
    endproperty
    a_bin_starts_write : assert property (p_bin_starts_write)
        else $error("accepted bin did not start a history write");

    property p_finish_after_drain;
        @(posedge clk) disable iff (!rst_n)
        $rose(state_reg == sdl_pkg::ST_FINISH) |-> !$past(status.pipe_busy);
    endproperty
    a_finish_after_drain : assert property (p_finish_after_drain)
        else $error("result formed before the mac pipeline drained");

endmodule

@@ hw/rtl/sdl_datapath.sv @@
// sdl_datapath: history and coefficient memories, complex mac pipeline,
// rounding and output register; depends on sdl_pkg
module sdl_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sdl_pkg::PCNT_W-1:0]        cfg_data,
    input  sdl_pkg::cmd_t                     cmd,
    output sdl_pkg::status_t                  status,
    input  logic signed [sdl_pkg::DATA_W-1:0] value_re,
    input  logic signed [sdl_pkg::DATA_W-1:0] value_im,
    input  logic                              frame_last,
    input  logic [sdl_pkg::SLOT_W-1:0]        coef_partition,
    input  logic [sdl_pkg::BIN_W-1:0]         coef_bin,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic signed [sdl_pkg::DATA_W-1:0] out_re,
    output logic signed [sdl_pkg::DATA_W-1:0] out_im,
    output logic                              out_last,
    output logic                              saturated
);

    localparam int DW  = sdl_pkg::DATA_W;
    localparam int AW  = sdl_pkg::ADDR_W;
    localparam int PW  = sdl_pkg::PROD_W;
    localparam int CW  = sdl_pkg::ACC_W;
    localparam int FW  = sdl_pkg::FRAC_W;
    localparam int SW  = sdl_pkg::SLOT_W;
    localparam int NW  = sdl_pkg::PCNT_W;
    localparam int BW  = sdl_pkg::BIN_W;
    localparam int QW  = CW + 1 - FW;

    // round to nearest, ties up, then clip; bit DW is the clip flag
    function automatic logic [DW:0] round_sat(input logic signed [CW-1:0] acc);
        logic signed [CW:0] t;
        logic [QW-1:0]      q;
        logic               pos_ovf;
        logic               neg_ovf;
        logic [DW:0]        r;
        t = {acc[CW-1], acc} + ((CW + 1)'(1) << (FW - 1));
        q = t[CW:FW];
        pos_ovf = !q[QW-1] && (|q[QW-2:DW-1]);
        neg_ovf = q[QW-1] && !(&q[QW-2:DW-1]);
        if (pos_ovf)
        begin
            r = {1'b1, 1'b0, {(DW - 1){1'b1}}};
        end
        else if (neg_ovf)
        begin
            r = {1'b1, 1'b1, {(DW - 1){1'b0}}};
        end
        else
        begin
            r = {1'b0, q[DW-1:0]};
        end
        return r;
    endfunction

    logic [2*DW-1:0] hist_mem [sdl_pkg::HIST_DEPTH];
    logic [2*DW-1:0] coef_mem [sdl_pkg::HIST_DEPTH];

    // control state
    logic [NW-1:0] parts_reg,  parts_next;
    logic [SW-1:0] slot_reg,   slot_next;
    logic [BW-1:0] bin_reg,    bin_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [SW-1:0] idx_reg,    idx_next;
    logic          v1_reg,     v1_next;
    logic          v2_reg,     v2_next;
    logic          res_valid_reg, res_valid_next;

    // payload
    logic signed [DW-1:0] item_re_reg, item_im_reg;
    logic                 item_last_reg;
    logic [2*DW-1:0]      hist_rd_reg, coef_rd_reg;
    logic signed [PW-1:0] prod_ac_reg, prod_bd_reg, prod_ad_reg, prod_bc_reg;
    logic signed [CW-1:0] acc_re_reg, acc_im_reg, acc_re_next, acc_im_next;
    logic signed [DW-1:0] out_re_reg, out_im_reg;
    logic                 out_last_reg, sat_reg;

    logic [NW-1:0]        p_cnt;
    logic [NW-1:0]        hist_row_wide;
    logic [SW-1:0]        hist_row;
    logic [NW-1:0]        slot_inc;
    logic                 hist_we;
    logic [AW-1:0]        hist_waddr;
    logic [2*DW-1:0]      hist_wdata;
    logic signed [DW-1:0] a_re, a_im, c_re, c_im;
    logic [DW:0]          rnd_re, rnd_im;

    assign p_cnt    = sdl_pkg::part_count(parts_reg);
    assign slot_inc = {1'b0, slot_reg} + NW'(1);

    // history row of partition idx: (slot - idx) mod count
    assign hist_row_wide = (slot_reg >= idx_reg) ?
                           ({1'b0, slot_reg} - {1'b0, idx_reg}) :
                           ({1'b0, slot_reg} + p_cnt - {1'b0, idx_reg});
    assign hist_row = hist_row_wide[SW-1:0];

    assign status.clr_last  = (clr_addr_reg == AW'(sdl_pkg::HIST_DEPTH - 1));
    assign status.rd_last   = ({1'b0, idx_reg} == p_cnt - NW'(1));
    assign status.pipe_busy = v1_reg || v2_reg;
    assign status.out_free  = !res_valid_reg || res_ready;

    // history write port: clearing pass or the incoming bin
    assign hist_we    = cmd.clr_step || cmd.hist_wr;
    assign hist_waddr = cmd.clr_step ? clr_addr_reg : sdl_pkg::store_addr(slot_reg, bin_reg);
    assign hist_wdata = cmd.clr_step ? '0 : {item_re_reg, item_im_reg};

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (cmd.rd_issue)
        begin
            hist_rd_reg <= hist_mem[sdl_pkg::store_addr(hist_row, bin_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coef_wr)
        begin
            coef_mem[sdl_pkg::store_addr(coef_partition, coef_bin)] <= {value_re, value_im};
        end
        if (cmd.rd_issue)
        begin
            coef_rd_reg <= coef_mem[sdl_pkg::store_addr(idx_reg, bin_reg)];
        end
    end

    assign a_re = hist_rd_reg[2*DW-1:DW];
    assign a_im = hist_rd_reg[DW-1:0];
    assign c_re = coef_rd_reg[2*DW-1:DW];
    assign c_im = coef_rd_reg[DW-1:0];

    always_comb
    begin
        parts_next     = parts_reg;
        slot_next      = slot_reg;
        bin_next       = bin_reg;
        clr_addr_next  = clr_addr_reg;
        idx_next       = idx_reg;
        v1_next        = cmd.rd_issue;
        v2_next        = v1_reg;
        res_valid_next = res_valid_reg;

        if (cmd.clr_step)
        begin
            clr_addr_next = status.clr_last ? '0 : clr_addr_reg + AW'(1);
        end
        if (cmd.clr_start)
        begin
            slot_next = '0;
            bin_next  = '0;
        end
        if (cmd.hist_wr)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_issue)
        begin
            idx_next = idx_reg + SW'(1);
        end

        // advance slot and bin once the item is done
        if (cmd.out_load)
        begin
            if (item_last_reg)
            begin
                slot_next = (slot_inc == p_cnt) ? '0 : slot_inc[SW-1:0];
                bin_next  = '0;
            end
            else
            begin
                bin_next = (bin_reg == BW'(sdl_pkg::BIN_COUNT - 1)) ? '0 : bin_reg + BW'(1);
            end
        end

        if (cfg_we)
        begin
            parts_next = cfg_data;
            if ({1'b0, slot_reg} >= sdl_pkg::part_count(cfg_data))
            begin
                slot_next = '0;
            end
        end

        if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parts_reg     <= NW'(1);
            slot_reg      <= '0;
            bin_reg       <= '0;
            clr_addr_reg  <= '0;
            idx_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            parts_reg     <= parts_next;
            slot_reg      <= slot_next;
            bin_reg       <= bin_next;
            clr_addr_reg  <= clr_addr_next;
            idx_reg       <= idx_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // products are exact q8.40, sums kept exact in the accumulator
    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (cmd.hist_wr)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (v2_reg)
        begin
            acc_re_next = acc_re_reg + CW'(prod_ac_reg) - CW'(prod_bd_reg);
            acc_im_next = acc_im_reg + CW'(prod_ad_reg) + CW'(prod_bc_reg);
        end
    end

    assign rnd_re = round_sat(acc_re_reg);
    assign rnd_im = round_sat(acc_im_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.bin_take)
        begin
            item_re_reg   <= value_re;
            item_im_reg   <= value_im;
            item_last_reg <= frame_last;
        end
        if (v1_reg)
        begin
            prod_ac_reg <= a_re * c_re;
            prod_bd_reg <= a_im * c_im;
            prod_ad_reg <= a_re * c_im;
            prod_bc_reg <= a_im * c_re;
        end
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
        if (cmd.out_load)
        begin
            out_re_reg   <= rnd_re[DW-1:0];
            out_im_reg   <= rnd_im[DW-1:0];
            out_last_reg <= item_last_reg;
            sat_reg      <= rnd_re[DW] || rnd_im[DW];
        end
    end

    assign res_valid = res_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign out_last  = out_last_reg;
    assign saturated = sat_reg;

    property p_slot_in_ring;
        @(posedge clk) disable iff (!rst_n)
        {1'b0, slot_reg} < p_cnt;
    endproperty
    a_slot_in_ring : assert property (p_slot_in_ring)
        else $error("write slot outside the partition ring");

    property p_read_in_ring;
        @(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> ({1'b0, idx_reg} < p_cnt);
    endproperty
    a_read_in_ring : assert property (p_read_in_ring)
        else $error("partition read beyond partition count");

    property p_no_result_overwrite;
        @(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready |-> !cmd.out_load;
    endproperty
    a_no_result_overwrite : assert property (p_no_result_overwrite)
        else $error("waiting result overwritten");

    property p_one_mem_cmd;
        @(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_step, cmd.hist_wr, cmd.rd_issue, cmd.out_load});
    endproperty
    a_one_mem_cmd : assert property (p_one_mem_cmd)
        else $error("conflicting datapath commands");

endmodule

@@ hw/rtl/spectral_delay_line_mac.sv @@
// spectral_delay_line_mac: an accepted bin is written into history, then one read per partition
// (P = partitions in use, 1..16) feeds the mac pipeline; once it drains, the rounded sum goes to
// the result register; the next item is taken only then, and later while a waiting result is not taken
// coefficient loads are taken while idle; a clear zeroes one history word per cycle
// after reset the same clearing pass runs before the first item is taken
// depends on sdl_pkg, sdl_if, sdl_ctrl, sdl_datapath
module spectral_delay_line_mac (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sdl_pkg::PCNT_W-1:0]  cfg_data,
    sdl_in_if.sink                      samples,
    sdl_out_if.source                   products
);

    // command and status between sequencer and datapath
    sdl_pkg::cmd_t    cmd;
    sdl_pkg::status_t status;

    // sequencer: owns the input handshake, walks clear, write, read, drain, finish
    sdl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (samples.valid),
        .item_kind  (samples.kind),
        .item_ready (samples.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: memories, four 24x24 multipliers, two exact accumulators,
    // rounding and the result register that frees the input side
    sdl_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status),
        .value_re       (samples.value_re),
        .value_im       (samples.value_im),
        .frame_last     (samples.frame_last),
        .coef_partition (samples.coef_partition),
        .coef_bin       (samples.coef_bin),
        .res_valid      (products.valid),
        .res_ready      (products.ready),
        .out_re         (products.out_re),
        .out_im         (products.out_im),
        .out_last       (products.out_last),
        .saturated      (products.saturated)
    );

endmodule

@@ sim/spectral_delay_line_mac_tb.sv @@
`timescale 1ns / 1ps
// spectral_delay_line_mac_tb: self-checking bench for the spectral delay line mac
// keeps its own copy of the history ring and coefficient taps, checks every product beat
// depends on sdl_pkg, sdl_if and the spectral_delay_line_mac rtl
module spectral_delay_line_mac_tb;
    import sdl_pkg::*;

    // kind 3 has no meaning, the block drops it
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

    // a clear walks all 8192 history words, so the block may still be busy
    // this long after the last product beat
    localparam int SETTLE_CYCLES = 8300;
    // the tail wait covers the longest bin with margin
    localparam int TAIL_CYCLES   = 40;
    localparam int MAX_PRINTED   = 40;
    // one frame past the bin count forces the bin position to wrap
    localparam int WRAP_FRAME    = BIN_COUNT + 8;

    typedef logic signed [DATA_W-1:0] q_t;

    localparam q_t Q_TOP    = {1'b0, {(DATA_W-1){1'b1}}};
    localparam q_t Q_BOTTOM = {1'b1, {(DATA_W-1){1'b0}}};
    localparam q_t Q_ONE    = q_t'(1 << FRAC_W);
    localparam q_t Q_HALF   = q_t'(1 << (FRAC_W - 1));

    typedef struct {
        logic [KIND_W-1:0] kind;
        q_t                value_re;
        q_t                value_im;
        logic              frame_last;
        logic [SLOT_W-1:0] coef_partition;
        logic [BIN_W-1:0]  coef_bin;
    } sample_t;

    typedef struct {
        q_t   out_re;
        q_t   out_im;
        logic out_last;
        logic saturated;
    } product_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [PCNT_W-1:0] cfg_data;

    sdl_in_if  samples_if ();
    sdl_out_if products_if ();

    spectral_delay_line_mac u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .samples  (samples_if),
        .products (products_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // bench copy of the block state
    // ------------------------------------------------------------------
    q_t                echo_re [HIST_DEPTH];   // past frames, one word per slot and bin
    q_t                echo_im [HIST_DEPTH];
    q_t                tap_re  [HIST_DEPTH];   // filter taps, one word per partition and bin
    q_t                tap_im  [HIST_DEPTH];
    logic [SLOT_W-1:0] ring_slot;
    logic [BIN_W-1:0]  ring_bin;
    logic [PCNT_W-1:0] ring_size_raw;

    product_t          product_q [$];          // products owed by the block, oldest first
    int unsigned       err_count;

    // ------------------------------------------------------------------
    // stimulus planning: runs ahead of the handshake, so it keeps its own
    // view of the bin position and of which taps have been loaded
    // ------------------------------------------------------------------
    sample_t           pending_q [$];
    bit                coef_known [HIST_DEPTH];
    int unsigned       plan_bin;
    int unsigned       plan_parts;
    int unsigned       items_made;
    int unsigned       clears_left;

    sample_t           in_flight;
    int unsigned       gap_left;
    int unsigned       stall_left;
    bit                calm;                   // no idling on either side once set

    // register 0 behaves as one partition, anything above the maximum as the maximum
    function automatic int unsigned ring_size(input logic [PCNT_W-1:0] raw);
        int unsigned n;
        n = raw;
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_PARTITIONS)
        begin
            n = MAX_PARTITIONS;
        end
        return n;
    endfunction

    // q8.40 sum to q4.20: nearest, ties toward plus infinity, then clip
    // top bit of the result is the clip flag
    function automatic logic [DATA_W:0] round_clip(input longint acc);
        longint q;
        q = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        if (q > longint'(Q_TOP))
        begin
            return {1'b1, Q_TOP};
        end
        if (q < longint'(Q_BOTTOM))
        begin
            return {1'b1, Q_BOTTOM};
        end
        return {1'b0, q[DATA_W-1:0]};
    endfunction

    task automatic reset_model();
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            echo_re[k]    = '0;
            echo_im[k]    = '0;
            tap_re[k]     = '0;
            tap_im[k]     = '0;
            coef_known[k] = 1'b0;
        end
        ring_slot     = '0;
        ring_bin      = '0;
        ring_size_raw = PCNT_W'(1);
    endtask

    task automatic set_ring_size(input logic [PCNT_W-1:0] raw);
        ring_size_raw = raw;
        // a slot beyond the new ring restarts at zero, history stays
        if (ring_slot >= ring_size(raw))
        begin
            ring_slot = '0;
        end
    endtask

    // apply one accepted input beat to the bench state, queue its product
    task automatic absorb_sample(input sample_t s);
        int unsigned p;
        int unsigned slot;
        int unsigned h;
        int unsigned row;
        longint      a;
        longint      b;
        longint      c;
        longint      d;
        longint      acc_re;
        longint      acc_im;
        logic [DATA_W:0] r_re;
        logic [DATA_W:0] r_im;
        product_t    e;
        case (s.kind)
            KIND_COEF:
            begin
                row = int'(s.coef_partition) * BIN_COUNT + int'(s.coef_bin);
                tap_re[row] = s.value_re;
                tap_im[row] = s.value_im;
            end
            KIND_CLEAR:
            begin
                for (int k = 0; k < HIST_DEPTH; k++)
                begin
                    echo_re[k] = '0;
                    echo_im[k] = '0;
                end
                ring_slot = '0;
                ring_bin  = '0;
            end
            KIND_BIN:
            begin
                p    = ring_size(ring_size_raw);
                slot = (ring_slot < p) ? ring_slot : 0;
                echo_re[slot * BIN_COUNT + ring_bin] = s.value_re;
                echo_im[slot * BIN_COUNT + ring_bin] = s.value_im;
                acc_re = 0;
                acc_im = 0;
                // partition i pairs with the frame i steps back in the ring
                for (int unsigned i = 0; i < p; i++)
                begin
                    h = (slot + p - i) % p;
                    a = echo_re[h * BIN_COUNT + ring_bin];
                    b = echo_im[h * BIN_COUNT + ring_bin];
                    c = tap_re[i * BIN_COUNT + ring_bin];
                    d = tap_im[i * BIN_COUNT + ring_bin];
                    acc_re += a * c - b * d;
                    acc_im += a * d + b * c;
                end
                r_re        = round_clip(acc_re);
                r_im        = round_clip(acc_im);
                e.out_re    = r_re[DATA_W-1:0];
                e.out_im    = r_im[DATA_W-1:0];
                e.out_last  = s.frame_last;
                e.saturated = r_re[DATA_W] | r_im[DATA_W];
                product_q.push_back(e);
                if (s.frame_last)
                begin
                    ring_slot = SLOT_W'((slot + 1) % p);
                    ring_bin  = '0;
                end
                else
                begin
                    // an overlong frame wraps the bin but keeps the slot
                    ring_bin  = (ring_bin == BIN_W'(BIN_COUNT - 1)) ? '0 : ring_bin + 1'b1;
                    ring_slot = SLOT_W'(slot);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED)
        begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_product();
        product_t e;
        if (product_q.size() == 0)
        begin
            report_mismatch($sformatf("product beat re %0d im %0d with no bin waiting",
                                      products_if.out_re, products_if.out_im));
        end
        else
        begin
            e = product_q.pop_front();
            if (products_if.out_re !== e.out_re)
            begin
                report_mismatch($sformatf("out_re got %0d expected %0d",
                                          products_if.out_re, e.out_re));
            end
            if (products_if.out_im !== e.out_im)
            begin
                report_mismatch($sformatf("out_im got %0d expected %0d",
                                          products_if.out_im, e.out_im));
            end
            if (products_if.out_last !== e.out_last)
            begin
                report_mismatch($sformatf("out_last got %b expected %b",
                                          products_if.out_last, e.out_last));
            end
            if (products_if.saturated !== e.saturated)
            begin
                report_mismatch($sformatf("saturated got %b expected %b",
                                          products_if.saturated, e.saturated));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: one beat in flight, random gap bursts after accepted beats
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_if.valid          <= 1'b0;
            samples_if.kind           <= KIND_BIN;
            samples_if.value_re       <= '0;
            samples_if.value_im       <= '0;
            samples_if.frame_last     <= 1'b0;
            samples_if.coef_partition <= '0;
            samples_if.coef_bin       <= '0;
            gap_left = 0;
        end
        else
        begin
            if (samples_if.valid && samples_if.ready)
            begin
                absorb_sample(in_flight);
            end
            // only move on once the current beat is gone
            if (!samples_if.valid || samples_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    samples_if.valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    in_flight = pending_q.pop_front();
                    samples_if.kind           <= in_flight.kind;
                    samples_if.value_re       <= in_flight.value_re;
                    samples_if.value_im       <= in_flight.value_im;
                    samples_if.frame_last     <= in_flight.frame_last;
                    samples_if.coef_partition <= in_flight.coef_partition;
                    samples_if.coef_bin       <= in_flight.coef_bin;
                    samples_if.valid          <= 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0)
                    begin
                        gap_left = $urandom_range(1, 10);
                    end
                end
                else
                begin
                    samples_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each product beat, stalls ready in random bursts
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            products_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (products_if.valid && products_if.ready)
            begin
                check_product();
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                products_if.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                // ready drops in this cycle and stays low until the remaining count runs out
                stall_left = $urandom_range(1, 10) - 1;
                products_if.ready <= 1'b0;
            end
            else
            begin
                products_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus building blocks
    // ------------------------------------------------------------------

    // mix of full scale, extremes, moderate and tiny values
    function automatic q_t rand_q();
        case ($urandom_range(0, 7))
            0:       return Q_TOP;
            1:       return Q_BOTTOM;
            2:       return '0;
            3, 4:    return q_t'($urandom);
            5, 6:    return q_t'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
            default: return q_t'(int'($urandom_range(0, 128)) - 64);
        endcase
    endfunction

    // every field random, callers then set what matters for the kind
    function automatic sample_t scrambled(input logic [KIND_W-1:0] kind);
        sample_t s;
        s.kind           = kind;
        s.value_re       = q_t'($urandom);
        s.value_im       = q_t'($urandom);
        s.frame_last     = 1'($urandom);
        s.coef_partition = SLOT_W'($urandom);
        s.coef_bin       = BIN_W'($urandom);
        return s;
    endfunction

    task automatic queue_item(input sample_t s);
        pending_q.push_back(s);
        if (s.kind != KIND_NOP)
        begin
            items_made++;
        end
    endtask

    task automatic queue_load(input int unsigned part, input int unsigned bin,
                              input q_t re, input q_t im);
        sample_t s;
        s = scrambled(KIND_COEF);
        s.coef_partition = SLOT_W'(part);
        s.coef_bin       = BIN_W'(bin);
        s.value_re       = re;
        s.value_im       = im;
        coef_known[part * BIN_COUNT + bin] = 1'b1;
        queue_item(s);
    endtask

    // a bin reads every tap of its position up to the ring size, so any tap
    // not yet loaded is loaded first with random content
    task automatic queue_bin(input q_t re, input q_t im, input bit closes);
        sample_t s;
        for (int unsigned i = 0; i < plan_parts; i++)
        begin
            if (!coef_known[i * BIN_COUNT + plan_bin])
            begin
                queue_load(i, plan_bin, rand_q(), rand_q());
            end
        end
        s = scrambled(KIND_BIN);
        s.value_re   = re;
        s.value_im   = im;
        s.frame_last = closes;
        queue_item(s);
        plan_bin = closes ? 0 : (plan_bin + 1) % BIN_COUNT;
    endtask

    task automatic queue_clear();
        queue_item(scrambled(KIND_CLEAR));
        plan_bin = 0;
    endtask

    task automatic queue_noise();
        queue_item(scrambled(KIND_NOP));
    endtask

    task automatic queue_frame(input int unsigned len, input bit closed);
        for (int unsigned k = 0; k < len; k++)
        begin
            queue_bin(rand_q(), rand_q(), closed && (k == len - 1));
        end
    endtask

    // sender holds back until every beat is taken and every product is back
    task automatic wait_quiet();
        while (pending_q.size() != 0 || samples_if.valid === 1'b1 || product_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic reconfigure(input logic [PCNT_W-1:0] raw);
        wait_quiet();
        // a trailing clear or load gives no product, let it finish
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= raw;
        set_ring_size(raw);
        plan_parts = ring_size(raw);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_directed();
        // taps for bin positions 0..2 of partition 0
        queue_load(0, 0, Q_ONE, '0);
        queue_load(0, 1, Q_BOTTOM, Q_BOTTOM);
        queue_load(0, 2, Q_HALF, '0);
        // unity tap passes full scale through untouched
        queue_bin(Q_TOP, Q_BOTTOM, 1'b0);
        // most negative squared: real part cancels, imaginary part clips
        queue_bin(Q_BOTTOM, Q_BOTTOM, 1'b0);
        // half an lsb each way: +0.5 rounds up, -0.5 rounds to zero
        queue_bin(q_t'(1), q_t'(-1), 1'b1);
        queue_noise();
        // top partition and top bin index
        queue_load(MAX_PARTITIONS - 1, BIN_COUNT - 1, Q_TOP, Q_TOP);
        queue_bin(Q_BOTTOM, Q_TOP, 1'b0);
        queue_bin('0, '0, 1'b0);
        // clear in the middle of a frame puts the bin back at zero
        queue_clear();
        queue_bin(q_t'(-1), q_t'(1), 1'b0);
        queue_bin(Q_TOP, Q_TOP, 1'b1);
        queue_noise();
        queue_bin(rand_q(), rand_q(), 1'b1);
        wait_quiet();
        queue_frame(3, 1'b1);
    endtask

    // mostly closed frames with random content, some loose taps, noise,
    // unterminated runs and the odd clear
    task automatic run_random(input int unsigned quota);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_made + quota;
        while (items_made < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                queue_frame(($urandom_range(0, 7) == 0) ? $urandom_range(5, 12)
                                                        : $urandom_range(1, 4), 1'b1);
            end
            else if (pick < 86)
            begin
                queue_load($urandom_range(0, MAX_PARTITIONS - 1),
                           $urandom_range(0, BIN_COUNT - 1), rand_q(), rand_q());
            end
            else if (pick < 91)
            begin
                queue_noise();
            end
            else if (pick < 97)
            begin
                queue_frame($urandom_range(1, 3), 1'b0);
            end
            else if (clears_left > 0)
            begin
                queue_clear();
                clears_left--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                     = 1'b0;
        cfg_we                    = 1'b0;
        cfg_data                  = '0;
        samples_if.valid          = 1'b0;
        samples_if.kind           = KIND_BIN;
        samples_if.value_re       = '0;
        samples_if.value_im       = '0;
        samples_if.frame_last     = 1'b0;
        samples_if.coef_partition = '0;
        samples_if.coef_bin       = '0;
        products_if.ready         = 1'b0;
        calm                      = 1'b0;
        err_count                 = 0;
        items_made                = 0;
        plan_bin                  = 0;
        plan_parts                = 1;
        clears_left               = 5;
        reset_model();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset ring size of one partition
        run_directed();

        // register 0 acts as one partition; one overlong frame wraps the bin
        reconfigure(PCNT_W'(0));
        queue_frame(WRAP_FRAME, 1'b1);

        // above the maximum clamps to sixteen partitions
        reconfigure(PCNT_W'(31));
        run_random(120);
        reconfigure(PCNT_W'(MAX_PARTITIONS));
        run_random(60);
        // shrinking the ring may pull the slot back to zero
        reconfigure(PCNT_W'(5));
        run_random(60);
        reconfigure(PCNT_W'(MAX_PARTITIONS + 1));
        run_random(60);
        reconfigure(PCNT_W'(1));
        run_random(40);

        // last stretch at full rate on both sides
        calm = 1'b1;
        reconfigure(PCNT_W'($urandom_range(2, MAX_PARTITIONS - 1)));
        run_random(60);

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && product_q.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
